// ===== rtl/rsse_pkg.sv =====
// Package: types, codes and constants shared by the stepper emulator modules.
`timescale 1ns / 1ps

package rsse_pkg;

  localparam int ACC_W       = 32;
  localparam int HALF_LO     = ACC_W / 2;
  localparam int HALF_W      = ACC_W - HALF_LO;
  localparam int DATA_W      = 32;
  localparam int REG_IDX_W   = 3;
  localparam int ADDR_W      = REG_IDX_W + 2;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [31:0] INDEX_SCALE = 32'd1000;

  typedef enum logic [1:0] {
    CMD_EDGE      = 2'd0,
    CMD_TICK      = 2'd1,
    CMD_EDGE_TICK = 2'd2,
    CMD_FORCE     = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    MC_MANUAL = 3'd0,
    MC_INDEX  = 3'd1,
    MC_SWEEP  = 3'd2,
    MC_ARREST = 3'd3,
    MC_TRACK  = 3'd4,
    MC_LOS    = 3'd5
  } mode_code_t;

  typedef enum logic [5:0] {
    M_MANUAL = 6'b000001,
    M_INDEX  = 6'b000010,
    M_SWEEP  = 6'b000100,
    M_ARREST = 6'b001000,
    M_TRACK  = 6'b010000,
    M_LOS    = 6'b100000
  } mode_t;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_UPPER_LIMIT   = 3'd0,
    REG_LOWER_LIMIT   = 3'd1,
    REG_ACCEL_STEP    = 3'd2,
    REG_INDEX_OFFSET  = 3'd3,
    REG_SWEEP_PERIOD  = 3'd4,
    REG_MANUAL_PERIOD = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [1:0] command;
    logic [2:0] new_mode;
    logic       drum_dir;
    logic       index_switch;
    logic       sweep_switch;
    logic       manual_left;
    logic       manual_right;
  } req_t;

  typedef struct packed {
    logic               step_pulse;
    logic               step_dir;
    logic [2:0]         mode_out;
    logic signed [31:0] position_out;
    logic signed [31:0] velocity_out;
    logic [31:0]        tick_period;
  } res_t;

  typedef struct packed {
    logic signed [31:0] upper_limit;
    logic signed [31:0] lower_limit;
    logic [30:0]        accel_step;
    logic [21:0]        index_offset_factor;
    logic [31:0]        sweep_period;
    logic [31:0]        manual_period;
  } cfg_t;

  typedef struct packed {
    logic             is_edge;
    logic             is_tick;
    logic             is_force;
    mode_t            force_mode;
    logic             drum_dir;
    logic             index_switch;
    logic             sweep_switch;
    logic             manual_left;
    logic             manual_right;
    logic [ACC_W-1:0] index_pos;
  } work_t;

  function automatic mode_t mode_onehot(input logic [2:0] code);
    mode_t m;
    unique case (code)
      MC_MANUAL: m = M_MANUAL;
      MC_INDEX:  m = M_INDEX;
      MC_SWEEP:  m = M_SWEEP;
      MC_ARREST: m = M_ARREST;
      MC_TRACK:  m = M_TRACK;
      MC_LOS:    m = M_LOS;
      default:   m = M_MANUAL;
    endcase
    return m;
  endfunction

  function automatic logic [2:0] mode_code(input mode_t m);
    logic [2:0] c;
    unique case (m)
      M_MANUAL: c = MC_MANUAL;
      M_INDEX:  c = MC_INDEX;
      M_SWEEP:  c = MC_SWEEP;
      M_ARREST: c = MC_ARREST;
      M_TRACK:  c = MC_TRACK;
      M_LOS:    c = MC_LOS;
      default:  c = MC_MANUAL;
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/reversing_screw_stepper_emulator.sv =====
// Top level: configuration registers, front stage, request queue and back stage.
//
//   channel | direction | handshake             | payload
//   req     | in        | req_valid / req_stall | req (command, mode, switches)
//   res     | out       | res_valid / res_stall | res (pulse, mode, position, ...)
//   cfg     | in        | APB psel / penable    | six registers at 4*index
//
// One request per cycle sustained while the result side does not stall; each request gives one result.
// A request passes through the front register, one queue slot and the result register.
// The back stage computes its position/velocity update combinationally from its registered state.
// Synchronous reset: mode index, arrest follow-on track, all but data registers zero.
// A stalled result holds the back stage; the queue lets the front accept until full.
`timescale 1ns / 1ps

module reversing_screw_stepper_emulator (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  output logic                          req_stall,
  input  rsse_pkg::req_t                req,
  output logic                          res_valid,
  input  logic                          res_stall,
  output rsse_pkg::res_t                res,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rsse_pkg::ADDR_W-1:0]   paddr,
  input  logic [rsse_pkg::DATA_W-1:0]   pwdata,
  output logic [rsse_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);

  rsse_pkg::cfg_t    cfg;
  rsse_pkg::reg_idx_t reg_idx;
  logic              cfg_write;
  logic              push;
  rsse_pkg::work_t   push_data;
  logic              q_full;
  logic              pop;
  logic              q_empty;
  rsse_pkg::work_t   head;

  assign pready    = 1'b1;
  assign reg_idx   = rsse_pkg::reg_idx_t'(paddr[rsse_pkg::ADDR_W-1:2]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_write) begin
      unique case (reg_idx)
        rsse_pkg::REG_UPPER_LIMIT:   cfg.upper_limit         <= pwdata;
        rsse_pkg::REG_LOWER_LIMIT:   cfg.lower_limit         <= pwdata;
        rsse_pkg::REG_ACCEL_STEP:    cfg.accel_step          <= pwdata[30:0];
        rsse_pkg::REG_INDEX_OFFSET:  cfg.index_offset_factor <= pwdata[21:0];
        rsse_pkg::REG_SWEEP_PERIOD:  cfg.sweep_period        <= pwdata;
        rsse_pkg::REG_MANUAL_PERIOD: cfg.manual_period       <= pwdata;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      rsse_pkg::REG_UPPER_LIMIT:   prdata = cfg.upper_limit;
      rsse_pkg::REG_LOWER_LIMIT:   prdata = cfg.lower_limit;
      rsse_pkg::REG_ACCEL_STEP:    prdata = 32'(cfg.accel_step);
      rsse_pkg::REG_INDEX_OFFSET:  prdata = 32'(cfg.index_offset_factor);
      rsse_pkg::REG_SWEEP_PERIOD:  prdata = cfg.sweep_period;
      rsse_pkg::REG_MANUAL_PERIOD: prdata = cfg.manual_period;
      default:                     prdata = '0;
    endcase
  end

  rsse_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .cfg       (cfg),
    .push      (push),
    .push_data (push_data),
    .q_full    (q_full)
  );

  rsse_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .empty     (q_empty),
    .head      (head)
  );

  rsse_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .empty     (q_empty),
    .head      (head),
    .pop       (pop),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

endmodule

// ===== rtl/rsse_front.sv =====
// Front stage: accept requests, decode the command and precompute the index position.
`timescale 1ns / 1ps

module rsse_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_stall,
  input  rsse_pkg::req_t       req,
  input  rsse_pkg::cfg_t       cfg,
  output logic                 push,
  output rsse_pkg::work_t      push_data,
  input  logic                 q_full
);

  logic                       fvalid;
  rsse_pkg::work_t            fwork;
  rsse_pkg::work_t            work_next;
  logic [31:0]                offset;
  logic                       accept;

  assign req_stall = fvalid && q_full;
  assign accept    = req_valid && !req_stall;
  assign push      = fvalid && !q_full;
  assign push_data = fwork;
  assign offset    = 32'(cfg.index_offset_factor) * rsse_pkg::INDEX_SCALE;

  always_comb begin
    work_next.is_edge      = (req.command == rsse_pkg::CMD_EDGE) ||
                             (req.command == rsse_pkg::CMD_EDGE_TICK);
    work_next.is_tick      = (req.command == rsse_pkg::CMD_TICK) ||
                             (req.command == rsse_pkg::CMD_EDGE_TICK);
    work_next.is_force     = (req.command == rsse_pkg::CMD_FORCE) &&
                             (req.new_mode <= rsse_pkg::MC_LOS);
    work_next.force_mode   = rsse_pkg::mode_onehot(req.new_mode);
    work_next.drum_dir     = req.drum_dir;
    work_next.index_switch = req.index_switch;
    work_next.sweep_switch = req.sweep_switch;
    work_next.manual_left  = req.manual_left;
    work_next.manual_right = req.manual_right;
    work_next.index_pos    = rsse_pkg::ACC_W'(cfg.upper_limit) -
                             rsse_pkg::ACC_W'(offset);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fvalid <= 1'b0;
    end else if (accept) begin
      fvalid <= 1'b1;
    end else if (push) begin
      fvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      fwork <= work_next;
    end
  end

endmodule

// ===== rtl/rsse_queue.sv =====
// Short queue of decoded requests between the front and back stages.
`timescale 1ns / 1ps

module rsse_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  rsse_pkg::work_t push_data,
  output logic            full,
  input  logic            pop,
  output logic            empty,
  output rsse_pkg::work_t head
);

  rsse_pkg::work_t                entries [rsse_pkg::QUEUE_DEPTH];
  logic [rsse_pkg::QPTR_W-1:0]    wr_ptr;
  logic [rsse_pkg::QPTR_W-1:0]    rd_ptr;
  logic [rsse_pkg::QCNT_W-1:0]    count;

  localparam logic [rsse_pkg::QPTR_W-1:0] LAST_PTR =
    rsse_pkg::QPTR_W'(rsse_pkg::QUEUE_DEPTH - 1);
  localparam logic [rsse_pkg::QCNT_W-1:0] FULL_COUNT =
    rsse_pkg::QCNT_W'(rsse_pkg::QUEUE_DEPTH);

  assign full  = (count == FULL_COUNT);
  assign empty = (count == '0);
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

`ifndef SYNTH
  a_no_push_full: assert property (@(posedge clk) disable iff (rst) full |-> !push)
    else $error("push into full queue");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst) empty |-> !pop)
    else $error("pop from empty queue");
`endif

endmodule

// ===== rtl/rsse_back.sv =====
// Back stage: run the mode logic and the screw emulation, hold the result register.
`timescale 1ns / 1ps

module rsse_back (
  input  logic            clk,
  input  logic            rst,
  input  rsse_pkg::cfg_t  cfg,
  input  logic            empty,
  input  rsse_pkg::work_t head,
  output logic            pop,
  output logic            res_valid,
  input  logic            res_stall,
  output rsse_pkg::res_t  res
);

  rsse_pkg::mode_t                     mode;
  rsse_pkg::mode_t                     arrest_next;
  logic signed [rsse_pkg::ACC_W-1:0]   position;
  logic signed [rsse_pkg::ACC_W-1:0]   velocity;
  logic                                dir_now;
  logic                                dir_last;
  logic [rsse_pkg::HALF_W-1:0]         upper_half_last;
  logic                                period_is_sweep;

  rsse_pkg::mode_t                     mode_next;
  rsse_pkg::mode_t                     arrest_next_next;
  logic signed [rsse_pkg::ACC_W-1:0]   position_next;
  logic signed [rsse_pkg::ACC_W-1:0]   velocity_next;
  logic                                dir_now_next;
  logic                                dir_last_next;
  logic [rsse_pkg::HALF_W-1:0]         upper_half_last_next;
  logic                                period_is_sweep_next;
  rsse_pkg::res_t                      res_next;

  logic signed [rsse_pkg::ACC_W-1:0]   upper_w;
  logic signed [rsse_pkg::ACC_W-1:0]   lower_w;
  logic signed [rsse_pkg::ACC_W-1:0]   accel_w;
  logic                                run;
  logic                                pulse;
  logic                                pdir;

  assign pop     = !empty && (!res_valid || !res_stall);
  assign upper_w = rsse_pkg::ACC_W'(cfg.upper_limit);
  assign lower_w = rsse_pkg::ACC_W'(cfg.lower_limit);
  assign accel_w = rsse_pkg::ACC_W'(cfg.accel_step);

  always_comb begin
    mode_next            = mode;
    arrest_next_next     = arrest_next;
    position_next        = position;
    velocity_next        = velocity;
    dir_now_next         = dir_now;
    dir_last_next        = dir_last;
    upper_half_last_next = upper_half_last;
    period_is_sweep_next = period_is_sweep;
    run                  = 1'b0;
    pulse                = 1'b0;
    pdir                 = 1'b0;

    if (head.is_force) begin
      mode_next = head.force_mode;
    end else begin
      if (head.is_edge && (mode == rsse_pkg::M_TRACK || mode == rsse_pkg::M_LOS)) begin
        run          = 1'b1;
        dir_now_next = head.drum_dir;
      end
      if (head.is_tick) begin
        unique case (mode)
          rsse_pkg::M_MANUAL: begin
            if (head.manual_left) begin
              pulse = 1'b1;
            end else if (head.manual_right) begin
              pulse = 1'b1;
              pdir  = 1'b1;
            end
          end
          rsse_pkg::M_INDEX: begin
            if (head.index_switch) begin
              position_next        = head.index_pos;
              upper_half_last_next =
                head.index_pos[rsse_pkg::ACC_W-1 -: rsse_pkg::HALF_W];
              mode_next            = rsse_pkg::M_SWEEP;
            end
            run = 1'b1;
          end
          rsse_pkg::M_SWEEP: begin
            if (velocity == '0) begin
              period_is_sweep_next = 1'b1;
            end
            if (head.sweep_switch) begin
              mode_next        = rsse_pkg::M_ARREST;
              arrest_next_next = rsse_pkg::M_TRACK;
            end
            run = 1'b1;
          end
          rsse_pkg::M_ARREST: begin
            if (velocity == '0) begin
              mode_next            = arrest_next;
              period_is_sweep_next = 1'b0;
            end else begin
              run = 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
    end

    if (run) begin
      if (dir_now_next != dir_last) begin
        dir_last_next = dir_now_next;
        velocity_next = '0 - velocity;
      end else if (position_next >= upper_w) begin
        velocity_next = velocity - accel_w;
      end else if (lower_w >= position_next) begin
        velocity_next = velocity + accel_w;
      end
      position_next = position_next + velocity_next;
      if (position_next[rsse_pkg::ACC_W-1 -: rsse_pkg::HALF_W] != upper_half_last_next) begin
        upper_half_last_next = position_next[rsse_pkg::ACC_W-1 -: rsse_pkg::HALF_W];
        pulse                = 1'b1;
        pdir                 = |velocity_next[rsse_pkg::ACC_W-1 -: rsse_pkg::HALF_W];
      end
    end

    res_next.step_pulse   = pulse;
    res_next.step_dir     = pulse && pdir;
    res_next.mode_out     = rsse_pkg::mode_code(mode_next);
    res_next.position_out = 32'(position_next);
    res_next.velocity_out = 32'(velocity_next);
    res_next.tick_period  = period_is_sweep_next ? cfg.sweep_period : cfg.manual_period;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode            <= rsse_pkg::M_INDEX;
      arrest_next     <= rsse_pkg::M_TRACK;
      position        <= '0;
      velocity        <= '0;
      dir_now         <= 1'b0;
      dir_last        <= 1'b0;
      upper_half_last <= '0;
      period_is_sweep <= 1'b0;
      res_valid       <= 1'b0;
    end else begin
      if (pop) begin
        mode            <= mode_next;
        arrest_next     <= arrest_next_next;
        position        <= position_next;
        velocity        <= velocity_next;
        dir_now         <= dir_now_next;
        dir_last        <= dir_last_next;
        upper_half_last <= upper_half_last_next;
        period_is_sweep <= period_is_sweep_next;
        res_valid       <= 1'b1;
      end else if (!res_stall) begin
        res_valid       <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      res <= res_next;
    end
  end

`ifndef SYNTH
  a_force_mode: assert property (@(posedge clk) disable iff (rst)
      (pop && head.is_force) |=> (mode == $past(head.force_mode)))
    else $error("forced mode not taken");
  a_dir_needs_pulse: assert property (@(posedge clk) disable iff (rst)
      res_valid |-> !(res.step_dir && !res.step_pulse))
    else $error("step direction without pulse");
`endif

endmodule

// ===== verif/reversing_screw_stepper_emulator_tb.sv =====
// Testbench: stimulus, mode and integrator predictor, and result checks for the stepper emulator.
`timescale 1ns / 1ps

module reversing_screw_stepper_emulator_tb;

  localparam logic [31:0] OFFSET_SCALE = 32'd1000;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int          NUM_PHASES   = 12;
  localparam int          PHASE_ITEMS  = 100;

  logic                          clk;
  logic                          rst = 1'b1;
  logic                          req_valid = 1'b0;
  logic                          req_stall;
  rsse_pkg::req_t                req = '0;
  logic                          res_valid;
  logic                          res_stall = 1'b0;
  rsse_pkg::res_t                res;
  logic                          psel = 1'b0;
  logic                          penable = 1'b0;
  logic                          pwrite = 1'b0;
  logic [rsse_pkg::ADDR_W-1:0]   paddr = '0;
  logic [rsse_pkg::DATA_W-1:0]   pwdata = '0;
  logic [rsse_pkg::DATA_W-1:0]   prdata;
  logic                          pready;

  reversing_screw_stepper_emulator u_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  // Predictor state and register shadow
  rsse_pkg::cfg_t        shadow_cfg;
  rsse_pkg::mode_code_t  emu_mode;
  rsse_pkg::mode_code_t  emu_arrest_next;
  logic [31:0]           emu_pos;
  logic [31:0]           emu_vel;
  logic                  emu_dir_now;
  logic                  emu_dir_last;
  logic [15:0]           emu_half_last;
  logic                  emu_sweep_sel;

  rsse_pkg::res_t        results_due[$];
  logic [31:0]           reg_image [6];
  int                    mismatches = 0;
  int                    sent_items = 0;
  int unsigned           cycles = 0;
  bit                    req_up = 1'b0;
  bit                    send_idle = 1'b1;
  bit                    recv_idle = 1'b1;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAIL reversing_screw_stepper_emulator");
      $finish;
    end
  end

  task automatic reset_emulation();
    shadow_cfg      = '0;
    emu_mode        = rsse_pkg::MC_INDEX;
    emu_arrest_next = rsse_pkg::MC_TRACK;
    emu_pos         = '0;
    emu_vel         = '0;
    emu_dir_now     = 1'b0;
    emu_dir_last    = 1'b0;
    emu_half_last   = '0;
    emu_sweep_sel   = 1'b0;
  endtask

  function automatic rsse_pkg::res_t emulate(input rsse_pkg::req_t r);
    rsse_pkg::res_t o;
    logic           run;
    logic           pulse;
    logic           pdir;
    logic [31:0]    acc;
    logic [31:0]    ul;
    logic [31:0]    ll;
    run   = 1'b0;
    pulse = 1'b0;
    pdir  = 1'b0;
    acc   = {1'b0, shadow_cfg.accel_step};
    ul    = shadow_cfg.upper_limit;
    ll    = shadow_cfg.lower_limit;
    if (r.command == rsse_pkg::CMD_FORCE) begin
      if (r.new_mode <= rsse_pkg::MC_LOS) emu_mode = rsse_pkg::mode_code_t'(r.new_mode);
    end else begin
      if ((r.command == rsse_pkg::CMD_EDGE || r.command == rsse_pkg::CMD_EDGE_TICK) &&
          (emu_mode == rsse_pkg::MC_TRACK || emu_mode == rsse_pkg::MC_LOS)) begin
        run = 1'b1;
        emu_dir_now = r.drum_dir;
      end
      if (r.command == rsse_pkg::CMD_TICK || r.command == rsse_pkg::CMD_EDGE_TICK) begin
        case (emu_mode)
          rsse_pkg::MC_MANUAL: begin
            if (r.manual_left) begin
              pulse = 1'b1;
              pdir  = 1'b0;
            end else if (r.manual_right) begin
              pulse = 1'b1;
              pdir  = 1'b1;
            end
          end
          rsse_pkg::MC_INDEX: begin
            if (r.index_switch) begin
              emu_pos       = ul - 32'(shadow_cfg.index_offset_factor) * OFFSET_SCALE;
              emu_half_last = emu_pos[31:16];
              emu_mode      = rsse_pkg::MC_SWEEP;
            end
            run = 1'b1;
          end
          rsse_pkg::MC_SWEEP: begin
            if (emu_vel == '0) emu_sweep_sel = 1'b1;
            if (r.sweep_switch) begin
              emu_mode        = rsse_pkg::MC_ARREST;
              emu_arrest_next = rsse_pkg::MC_TRACK;
            end
            run = 1'b1;
          end
          rsse_pkg::MC_ARREST: begin
            if (emu_vel == '0) begin
              emu_mode      = emu_arrest_next;
              emu_sweep_sel = 1'b0;
            end else begin
              run = 1'b1;
            end
          end
          default: ;
        endcase
      end
    end
    if (run) begin
      if (emu_dir_now != emu_dir_last) begin
        emu_dir_last = emu_dir_now;
        emu_vel      = -emu_vel;
      end else if ($signed(emu_pos) >= $signed(ul)) begin
        emu_vel = emu_vel - acc;
      end else if ($signed(ll) >= $signed(emu_pos)) begin
        emu_vel = emu_vel + acc;
      end
      emu_pos = emu_pos + emu_vel;
      if (emu_pos[31:16] != emu_half_last) begin
        emu_half_last = emu_pos[31:16];
        pulse = 1'b1;
        pdir  = (emu_vel[31:16] != 16'd0);
      end
    end
    o.step_pulse   = pulse;
    o.step_dir     = pulse ? pdir : 1'b0;
    o.mode_out     = emu_mode;
    o.position_out = emu_pos;
    o.velocity_out = emu_vel;
    o.tick_period  = emu_sweep_sel ? shadow_cfg.sweep_period : shadow_cfg.manual_period;
    return o;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    $display("mismatch %s: got %h expected %h at cycle %0d", what, got, want, cycles);
  endtask

  task automatic compare_step(input rsse_pkg::res_t got, input rsse_pkg::res_t want);
    if (got.step_pulse !== want.step_pulse)
      report_mismatch("step_pulse", 32'(got.step_pulse), 32'(want.step_pulse));
    if (got.step_dir !== want.step_dir)
      report_mismatch("step_dir", 32'(got.step_dir), 32'(want.step_dir));
    if (got.mode_out !== want.mode_out)
      report_mismatch("mode_out", 32'(got.mode_out), 32'(want.mode_out));
    if (got.position_out !== want.position_out)
      report_mismatch("position_out", got.position_out, want.position_out);
    if (got.velocity_out !== want.velocity_out)
      report_mismatch("velocity_out", got.velocity_out, want.velocity_out);
    if (got.tick_period !== want.tick_period)
      report_mismatch("tick_period", got.tick_period, want.tick_period);
  endtask

  always @(posedge clk) begin
    if (!rst && res_valid === 1'b1 && res_stall === 1'b0) begin
      if (results_due.size() == 0) report_mismatch("result with none due", res.position_out, '0);
      else compare_step(res, results_due.pop_front());
    end
  end

  // Result side: while recv_idle is set, stall a random number of cycles before each result
  initial begin
    int hold;
    while (rst) @(posedge clk);
    forever begin
      hold = recv_idle ? $urandom_range(0, 6) : 0;
      if (hold > 0) begin
        res_stall <= 1'b1;
        repeat (hold) @(posedge clk);
        res_stall <= 1'b0;
      end
      do @(posedge clk); while (res_valid !== 1'b1);
    end
  end

  task automatic send(input rsse_pkg::req_t r);
    int gap;
    gap = send_idle ? $urandom_range(0, 6) : 0;
    if (gap > 0) begin
      if (req_up) begin
        req_valid <= 1'b0;
        req_up = 1'b0;
      end
      repeat (gap) @(posedge clk);
    end
    req <= r;
    if (!req_up) begin
      req_valid <= 1'b1;
      req_up = 1'b1;
    end
    do @(posedge clk); while (req_stall !== 1'b0);
    results_due.push_back(emulate(r));
    sent_items++;
  endtask

  task automatic wait_results_done();
    if (req_up) begin
      req_valid <= 1'b0;
      req_up = 1'b0;
    end
    while (results_due.size() != 0) @(posedge clk);
  endtask

  task automatic program_regs();
    for (int i = 0; i < 6; i++) begin
      psel    <= 1'b1;
      pwrite  <= 1'b1;
      penable <= 1'b0;
      paddr   <= {rsse_pkg::reg_idx_t'(i), 2'b00};
      pwdata  <= reg_image[i];
      @(posedge clk);
      penable <= 1'b1;
      do @(posedge clk); while (pready !== 1'b1);
      case (rsse_pkg::reg_idx_t'(i))
        rsse_pkg::REG_UPPER_LIMIT:   shadow_cfg.upper_limit         = reg_image[i];
        rsse_pkg::REG_LOWER_LIMIT:   shadow_cfg.lower_limit         = reg_image[i];
        rsse_pkg::REG_ACCEL_STEP:    shadow_cfg.accel_step          = reg_image[i][30:0];
        rsse_pkg::REG_INDEX_OFFSET:  shadow_cfg.index_offset_factor = reg_image[i][21:0];
        rsse_pkg::REG_SWEEP_PERIOD:  shadow_cfg.sweep_period        = reg_image[i];
        rsse_pkg::REG_MANUAL_PERIOD: shadow_cfg.manual_period       = reg_image[i];
        default: ;
      endcase
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic load_regs(input logic [31:0] ul, input logic [31:0] ll,
                           input logic [31:0] acc, input logic [31:0] off,
                           input logic [31:0] sp, input logic [31:0] mp);
    wait_results_done();
    reg_image[rsse_pkg::REG_UPPER_LIMIT]   = ul;
    reg_image[rsse_pkg::REG_LOWER_LIMIT]   = ll;
    reg_image[rsse_pkg::REG_ACCEL_STEP]    = acc;
    reg_image[rsse_pkg::REG_INDEX_OFFSET]  = off;
    reg_image[rsse_pkg::REG_SWEEP_PERIOD]  = sp;
    reg_image[rsse_pkg::REG_MANUAL_PERIOD] = mp;
    program_regs();
  endtask

  function automatic logic coin_flip();
    return 1'($urandom_range(0, 1));
  endfunction

  function automatic rsse_pkg::req_t noise_req();
    logic [31:0] raw;
    raw = $urandom;
    return rsse_pkg::req_t'(raw[$bits(rsse_pkg::req_t)-1:0]);
  endfunction

  function automatic rsse_pkg::req_t cmd_req(input rsse_pkg::cmd_t c);
    rsse_pkg::req_t r;
    r = noise_req();
    r.command = c;
    return r;
  endfunction

  function automatic rsse_pkg::req_t forced(input logic [2:0] m);
    rsse_pkg::req_t r;
    r = cmd_req(rsse_pkg::CMD_FORCE);
    r.new_mode = m;
    return r;
  endfunction

  function automatic rsse_pkg::cmd_t pick_tick();
    return ($urandom_range(0, 3) == 0) ? rsse_pkg::CMD_EDGE_TICK : rsse_pkg::CMD_TICK;
  endfunction

  task automatic send_tick(input logic idx_sw, input logic swp_sw);
    rsse_pkg::req_t r;
    r = cmd_req(pick_tick());
    r.index_switch = idx_sw;
    r.sweep_switch = swp_sw;
    send(r);
  endtask

  task automatic send_edge(input rsse_pkg::cmd_t c, input logic dir);
    rsse_pkg::req_t r;
    r = cmd_req(c);
    r.drum_dir = dir;
    send(r);
  endtask

  task automatic send_manual(input logic left, input logic right, input rsse_pkg::cmd_t c);
    rsse_pkg::req_t r;
    r = cmd_req(c);
    r.manual_left  = left;
    r.manual_right = right;
    send(r);
  endtask

  task automatic test_idle_defaults();
    send_edge(rsse_pkg::CMD_EDGE, 1'b1);
    send_tick(1'b0, 1'b1);
  endtask

  task automatic test_forced_modes();
    send(forced(3'd6));
    send(forced(3'd7));
    send(forced(rsse_pkg::MC_MANUAL));
  endtask

  task automatic test_manual_ticks();
    send_manual(1'b1, 1'b0, rsse_pkg::CMD_TICK);
    send_manual(1'b1, 1'b1, rsse_pkg::CMD_TICK);
    send_manual(1'b0, 1'b1, rsse_pkg::CMD_TICK);
    send_manual(1'b0, 1'b0, rsse_pkg::CMD_TICK);
    send_manual(1'b0, 1'b1, rsse_pkg::CMD_EDGE_TICK);
  endtask

  task automatic test_index_sweep_arrest();
    load_regs(32'h0003_0000, 32'hFFFD_0000, 32'h0000_8000, 32'h0, 32'h0000_1234,
              32'h0000_5678);
    send(forced(rsse_pkg::MC_INDEX));
    send_tick(1'b0, 1'b0);
    send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b0);
    send_tick(1'b0, 1'b1);
    send_tick(1'b0, 1'b0);
    send_tick(1'b0, 1'b0);
  endtask

  task automatic test_track_edges();
    send(forced(rsse_pkg::MC_TRACK));
    send_edge(rsse_pkg::CMD_EDGE, 1'b1);
    send_edge(rsse_pkg::CMD_EDGE, 1'b1);
    send_edge(rsse_pkg::CMD_EDGE_TICK, 1'b0);
    send(cmd_req(rsse_pkg::CMD_TICK));
    send(forced(rsse_pkg::MC_LOS));
    send_edge(rsse_pkg::CMD_EDGE, 1'b1);
    send(forced(rsse_pkg::MC_ARREST));
  endtask

  task automatic pick_settings(input int ph);
    int centre;
    case (ph)
      0: load_regs(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                   32'hFFFF_FFFF, 32'h0);
      1: load_regs(32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF);
      2: load_regs($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      default: begin
        centre = int'($urandom_range(0, 32'h40000)) - 32'h20000;
        load_regs(centre + int'($urandom_range(32'h4000, 32'h30000)),
                  centre - int'($urandom_range(32'h4000, 32'h30000)),
                  $urandom_range(32'h80, 32'h2000),
                  $urandom_range(0, 1) ? 32'h0 : $urandom_range(0, 400),
                  $urandom, $urandom);
      end
    endcase
  endtask

  task automatic run_scenario();
    int             pick;
    int             n;
    bit             broken;
    logic           dir;
    rsse_pkg::req_t r;
    pick   = $urandom_range(0, 99);
    broken = (pick < 35);
    if (pick < 20) begin
      repeat ($urandom_range(4, 16)) send(noise_req());
    end else begin
      send(forced(rsse_pkg::MC_INDEX));
      repeat ($urandom_range(0, 2)) send_tick(1'b0, coin_flip());
      send_tick(1'b1, coin_flip());
      repeat ($urandom_range(4, 40)) begin
        if (broken && $urandom_range(0, 9) == 0) send(noise_req());
        else send_tick(coin_flip(), 1'b0);
      end
      send_tick(coin_flip(), 1'b1);
      n = 0;
      while (emu_mode == rsse_pkg::MC_ARREST && n < 80) begin
        send_tick(coin_flip(), coin_flip());
        n++;
      end
      if ($urandom_range(0, 2) == 0) send(forced(rsse_pkg::MC_LOS));
      else if (emu_mode != rsse_pkg::MC_TRACK) send(forced(rsse_pkg::MC_TRACK));
      dir = emu_dir_now;
      repeat ($urandom_range(4, 40)) begin
        if ($urandom_range(0, 3) == 0) dir = ~dir;
        if (broken && $urandom_range(0, 9) == 0) send(noise_req());
        else send_edge(($urandom_range(0, 3) == 0) ? rsse_pkg::CMD_EDGE_TICK :
                       rsse_pkg::CMD_EDGE, dir);
      end
      send(forced(rsse_pkg::MC_MANUAL));
      repeat ($urandom_range(1, 6)) begin
        r = cmd_req(pick_tick());
        send(r);
      end
    end
  endtask

  task automatic test_random_phases();
    int phase_end;
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      pick_settings(ph);
      send_idle = ($urandom_range(0, 3) != 0);
      recv_idle = ($urandom_range(0, 3) != 0);
      phase_end = sent_items + PHASE_ITEMS;
      while (sent_items < phase_end) run_scenario();
    end
    send_idle = 1'b1;
    recv_idle = 1'b1;
  endtask

  initial begin
    reset_emulation();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_idle_defaults();
    test_forced_modes();
    test_manual_ticks();
    test_index_sweep_arrest();
    test_track_edges();
    test_random_phases();
    wait_results_done();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && results_due.size() == 0)
      $display("PASS reversing_screw_stepper_emulator");
    else
      $display("FAIL reversing_screw_stepper_emulator");
    $finish;
  end

endmodule
